// ===== sv/mono_pixel_frame_store_top_macros.svh =====
// assertion macros shared by the frame store checker
`ifndef MONO_PIXEL_FRAME_STORE_TOP_MACROS_SVH
`define MONO_PIXEL_FRAME_STORE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define MPFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frame store assertion failed");

// next-cycle implication, disabled while reset is low
`define MPFS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frame store assertion failed");

`endif

// ===== sv/mpfs_pkg.sv =====
// shared constants for the monochrome pixel frame store
package mpfs_pkg;

  localparam int unsigned CMD_W = 3;
  localparam int unsigned X_W   = 8;
  localparam int unsigned Y_W   = 8;
  localparam int unsigned IDX_W = 10;

  // input word: command, x, y, byte_index from bit 0 up
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned IN_X_LSB    = CMD_W;
  localparam int unsigned IN_Y_LSB    = CMD_W + X_W;
  localparam int unsigned IN_IDX_LSB  = CMD_W + X_W + Y_W;

  // output word: pixel, byte_data, in_range from bit 0 up
  localparam int unsigned OUT_TDATA_W = 16;

  // width of the linear pixel address before the store bound check
  localparam int unsigned LIN_W = 16;

  localparam logic [CMD_W-1:0] CMD_SET       = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TOGGLE    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_GET       = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR_ALL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ_BYTE = 3'd5;

endpackage

// ===== sv/mpfs_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
module mpfs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/mono_pixel_frame_store_top.sv =====
// top level of the monochrome one-bit-per-pixel frame store
// A COLUMNS x ROWS one-bit-per-pixel frame store held as FRAME_BYTES bytes in one
// synchronous ram, vertical layout: pixel (x, y) is bit y mod 8 of byte
// x*ceil(ROWS/8) + y/8. Each input word carries one command (set, clear, toggle,
// get pixel, clear all, read byte) and yields exactly one output word.
// For pixel and read-byte commands the ram read is issued as the word is accepted;
// ST_READ then modifies, writes back and answers once the output register is free,
// and only then is the next word taken. Clear all walks the ram one byte per cycle
// and answers from ST_DONE once the output register is free. After reset the same
// clearing pass runs over every byte with s_axis_tready low. Out-of-panel
// coordinates leave the store alone and return in_range 0; a finished result waits
// in an output register; the next word is still taken, then waits in ST_READ.
module mono_pixel_frame_store_top
  import mpfs_pkg::*;
#(
  parameter int unsigned COLUMNS     = 128,
  parameter int unsigned ROWS        = 64,
  parameter int unsigned FRAME_BYTES = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input word
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // command[2:0] x[10:3] y[18:11] byte_index[28:19]
  // result word
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // pixel[0] byte_data[8:1] in_range[9]
);

  localparam int unsigned BytesPerCol = (ROWS + 7) / 8;
  localparam int unsigned AddrW       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(FRAME_BYTES - 1);

  // sequencer states
  localparam logic [2:0] ST_INIT  = 3'd0;  // clearing pass after reset, no result
  localparam logic [2:0] ST_IDLE  = 3'd1;  // waiting for a word
  localparam logic [2:0] ST_READ  = 3'd2;  // ram data valid, modify and answer
  localparam logic [2:0] ST_CLEAR = 3'd3;  // clearing pass for clear all
  localparam logic [2:0] ST_DONE  = 3'd4;  // clear all finished, answer

  logic [2:0] state_q, state_d;
  logic [AddrW-1:0] sweep_q, sweep_d;

  // captured command
  logic [CMD_W-1:0] cmd_q;
  logic             ok_q;
  logic [2:0]       bit_q;
  logic [AddrW-1:0] addr_q;

  // output register
  logic       out_valid_q, out_valid_d;
  logic       out_pixel_q, out_pixel_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_range_q, out_range_d;
  logic       load_res;

  // input field decode
  logic [CMD_W-1:0] in_cmd;
  logic [X_W-1:0]   in_x;
  logic [Y_W-1:0]   in_y;
  logic [IDX_W-1:0] in_idx;
  logic [LIN_W-1:0] lin_addr;
  logic [LIN_W-1:0] idx_ext;
  logic             pix_ok;
  logic             idx_ok;
  logic             in_ok;
  logic [AddrW-1:0] in_addr;
  logic             accept;

  // ram side
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       ram_rdata;
  logic [7:0]       bit_mask;
  logic             slot_free;

  assign in_cmd = s_axis_tdata[CMD_W-1:0];
  assign in_x   = s_axis_tdata[IN_X_LSB +: X_W];
  assign in_y   = s_axis_tdata[IN_Y_LSB +: Y_W];
  assign in_idx = s_axis_tdata[IN_IDX_LSB +: IDX_W];

  // pixel location: column times bytes per column plus row / 8
  assign lin_addr = LIN_W'(in_x) * LIN_W'(BytesPerCol) + LIN_W'(in_y >> 3);
  assign idx_ext  = LIN_W'(in_idx);
  assign pix_ok   = (LIN_W'(in_x) < LIN_W'(COLUMNS)) && (LIN_W'(in_y) < LIN_W'(ROWS))
                 && (lin_addr < LIN_W'(FRAME_BYTES));
  assign idx_ok   = idx_ext < LIN_W'(FRAME_BYTES);

  always_comb begin
    in_ok   = 1'b1;
    in_addr = lin_addr[AddrW-1:0];
    case (in_cmd)
      CMD_SET, CMD_CLEAR, CMD_TOGGLE, CMD_GET: begin
        in_ok = pix_ok;
      end
      CMD_READ_BYTE: begin
        in_ok   = idx_ok;
        in_addr = idx_ext[AddrW-1:0];
      end
      default: begin
        in_ok = 1'b1;
      end
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // result slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_q || m_axis_tready;
  assign bit_mask  = 8'(1) << bit_q;

  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    ram_we      = 1'b0;
    ram_waddr   = addr_q;
    ram_wdata   = ram_rdata;
    load_res    = 1'b0;
    out_pixel_d = 1'b0;
    out_byte_d  = 8'd0;
    out_range_d = 1'b1;
    case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = 8'd0;
        sweep_d   = sweep_q + AddrW'(1);
        if (sweep_q == LastAddr) begin
          sweep_d = '0;
          state_d = (state_q == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_cmd == CMD_CLEAR_ALL) ? ST_CLEAR : ST_READ;
        end
      end
      ST_READ: begin
        if (slot_free) begin
          load_res    = 1'b1;
          out_range_d = ok_q;
          state_d     = ST_IDLE;
          case (cmd_q)
            CMD_SET: begin
              ram_we    = ok_q;
              ram_wdata = ram_rdata | bit_mask;
            end
            CMD_CLEAR: begin
              ram_we    = ok_q;
              ram_wdata = ram_rdata & ~bit_mask;
            end
            CMD_TOGGLE: begin
              ram_we    = ok_q;
              ram_wdata = ram_rdata ^ bit_mask;
            end
            CMD_GET: begin
              out_pixel_d = ok_q && ((ram_rdata & bit_mask) != 8'd0);
            end
            CMD_READ_BYTE: begin
              out_byte_d = ok_q ? ram_rdata : 8'd0;
            end
            default: begin
              out_range_d = 1'b1;
            end
          endcase
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          load_res = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_INIT;
        sweep_d = '0;
      end
    endcase
  end

  always_comb begin
    if (load_res) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      out_valid_q <= out_valid_d;
    end
  end

  // captured command and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= in_cmd;
      ok_q   <= in_ok;
      bit_q  <= in_y[2:0];
      addr_q <= in_addr;
    end
    if (load_res) begin
      out_pixel_q <= out_pixel_d;
      out_byte_q  <= out_byte_d;
      out_range_q <= out_range_d;
    end
  end

  // read is issued at accept; the registered data is used in ST_READ, which may wait for a free result slot
  mpfs_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_addr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_range_q, out_byte_q, out_pixel_q};

endmodule

// ===== sv/mpfs_checker.sv =====
// port-level checker for the frame store, bound to the top level
`include "mono_pixel_frame_store_top_macros.svh"

module mpfs_checker
  import mpfs_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic in_word;
  logic out_stall;

  assign in_word   = s_axis_tvalid && s_axis_tready;
  assign out_stall = m_axis_tvalid && !m_axis_tready;

  // a stalled result word stays put
  `MPFS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid && $stable(m_axis_tdata))

  // one word at a time: no new input right after one is taken
  `MPFS_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, in_word, !s_axis_tready)

  // a fresh result needs the ram read cycle first
  `MPFS_ASSERT_NXT(a_read_latency, clk_i, rst_ni, in_word,
                   !m_axis_tvalid || $past(m_axis_tvalid))

  // clearing pass holds off input right after reset
  `MPFS_ASSERT_NOW(a_init_sweep, clk_i, rst_ni, !$past(rst_ni), !s_axis_tready)

endmodule

bind mono_pixel_frame_store_top mpfs_checker u_mpfs_checker (.*);

// ===== bench/mono_pixel_frame_store_top_tb.sv =====
// testbench for the monochrome one-bit-per-pixel frame store top level
module mono_pixel_frame_store_top_tb;
  import mpfs_pkg::*;

  localparam int unsigned COLUMNS       = 128;
  localparam int unsigned ROWS          = 64;
  localparam int unsigned FRAME_BYTES   = 1024;
  localparam int unsigned SHADOW_AW     = $clog2(FRAME_BYTES);
  localparam int unsigned BYTES_PER_COL = (ROWS + 7) / 8;
  localparam int unsigned X_MAX         = 2**X_W - 1;
  localparam int unsigned Y_MAX         = 2**Y_W - 1;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  // codes the block leaves unused
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  // result word layout: pixel, byte_data, in_range from bit 0 up
  localparam int unsigned OUT_PIXEL_BIT = 0;
  localparam int unsigned OUT_BYTE_LSB  = 1;
  localparam int unsigned OUT_RANGE_BIT = 9;

  typedef struct packed {
    logic       pixel;
    logic [7:0] byte_data;
    logic       in_range;
  } frame_result_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // shadow copy of the panel memory and the results still owed by the block
  logic [7:0]    frame_shadow [FRAME_BYTES];
  frame_result_t owed_results [$];

  int unsigned words_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned clear_all_count = 0;
  int unsigned off_panel_count = 0;
  int unsigned cycle_count     = 0;

  // idling control shared by the stimulus tasks and the result sink
  int unsigned src_idle_pct  = 0;
  int unsigned sink_idle_pct = 0;
  int unsigned sink_hold_len = 0;
  int unsigned hot_column    = 0;
  int unsigned hot_row       = 0;

  mono_pixel_frame_store_top #(
    .COLUMNS    (COLUMNS),
    .ROWS       (ROWS),
    .FRAME_BYTES(FRAME_BYTES)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // applies one command word to the shadow memory and returns the result it owes
  function automatic frame_result_t apply_pixel_command(logic [IN_TDATA_W-1:0] w);
    logic [CMD_W-1:0]     op;
    logic [X_W-1:0]       px;
    logic [Y_W-1:0]       py;
    logic [IDX_W-1:0]     idx;
    int unsigned          addr;
    logic [SHADOW_AW-1:0] slot;
    logic [7:0]           mask;
    logic                 on_panel;
    frame_result_t        r;
    op       = w[CMD_W-1:0];
    px       = w[IN_X_LSB +: X_W];
    py       = w[IN_Y_LSB +: Y_W];
    idx      = w[IN_IDX_LSB +: IDX_W];
    r        = '0;
    r.in_range = 1'b1;
    addr     = px * BYTES_PER_COL + (py >> 3);
    slot     = addr[SHADOW_AW-1:0];
    mask     = 8'd1 << py[2:0];
    on_panel = (px < COLUMNS) && (py < ROWS) && (addr < FRAME_BYTES);
    case (op)
      CMD_SET, CMD_CLEAR, CMD_TOGGLE, CMD_GET: begin
        if (!on_panel) begin
          r.in_range = 1'b0;
          off_panel_count++;
        end else begin
          case (op)
            CMD_SET:    frame_shadow[slot] = frame_shadow[slot] | mask;
            CMD_CLEAR:  frame_shadow[slot] = frame_shadow[slot] & ~mask;
            CMD_TOGGLE: frame_shadow[slot] = frame_shadow[slot] ^ mask;
            default:    r.pixel = |(frame_shadow[slot] & mask);
          endcase
        end
      end
      CMD_CLEAR_ALL: begin
        foreach (frame_shadow[i]) frame_shadow[i] = '0;
        clear_all_count++;
      end
      CMD_READ_BYTE: begin
        if (idx < FRAME_BYTES) r.byte_data = frame_shadow[idx];
        else r.in_range = 1'b0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // every accepted command word is predicted in order of acceptance
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      owed_results.push_back(apply_pixel_command(s_axis_tdata));
  end

  always @(posedge clk_i) begin : result_check
    frame_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result word %h arrived, expected none", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        if (m_axis_tdata[OUT_PIXEL_BIT] !== want.pixel) begin
          $display("%0t: pixel expected %0d actual %0d", $time, want.pixel,
                   m_axis_tdata[OUT_PIXEL_BIT]);
          mismatch_count++;
        end
        if (m_axis_tdata[OUT_BYTE_LSB +: 8] !== want.byte_data) begin
          $display("%0t: byte_data expected %h actual %h", $time, want.byte_data,
                   m_axis_tdata[OUT_BYTE_LSB +: 8]);
          mismatch_count++;
        end
        if (m_axis_tdata[OUT_RANGE_BIT] !== want.in_range) begin
          $display("%0t: in_range expected %0d actual %0d", $time, want.in_range,
                   m_axis_tdata[OUT_RANGE_BIT]);
          mismatch_count++;
        end
      end
    end
  end

  // result sink: random stall bursts, plus a long hold-off on request
  initial begin : result_sink
    forever begin
      @(negedge clk_i);
      if (sink_hold_len != 0) begin
        m_axis_tready = 1'b0;
        repeat (sink_hold_len) @(negedge clk_i);
        sink_hold_len = 0;
      end else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycle_count,
             owed_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  // offers one command word from a falling edge and returns at a falling edge
  task automatic send_word(input logic [CMD_W-1:0] op, input int unsigned px,
                           input int unsigned py, input int unsigned idx);
    s_axis_tdata  = {{(IN_TDATA_W - IN_IDX_LSB - IDX_W){1'b0}}, IDX_W'(idx), Y_W'(py),
                     X_W'(px), op};
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    words_sent++;
    @(negedge clk_i);
    if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained;
    s_axis_tvalid = 1'b0;
    while (owed_results.size() != 0) @(negedge clk_i);
  endtask

  // mostly pixel traffic around a hot spot so gets and byte reads see set bits
  task automatic send_random_word;
    int unsigned      pick;
    logic [CMD_W-1:0] op;
    int unsigned      px;
    int unsigned      py;
    int unsigned      idx;
    pick = $urandom_range(0, 99);
    px   = $urandom_range(0, X_MAX);
    py   = $urandom_range(0, Y_MAX);
    idx  = $urandom_range(0, 2**IDX_W - 1);
    if (pick < 3) begin
      op = CMD_CLEAR_ALL;
    end else if (pick < 6) begin
      op = pick[0] ? CMD_SPARE_6 : CMD_SPARE_7;
    end else if (pick < 14) begin
      // off the panel in x, or in y with x on the panel
      op = CMD_W'($urandom_range(CMD_SET, CMD_GET));
      if ($urandom_range(0, 1)) begin
        px = $urandom_range(COLUMNS, X_MAX);
      end else begin
        px = $urandom_range(0, COLUMNS - 1);
        py = $urandom_range(ROWS, Y_MAX);
      end
    end else if (pick < 32) begin
      op = CMD_READ_BYTE;
      if ($urandom_range(0, 3) != 0)
        idx = (hot_column + $urandom_range(0, 7)) * BYTES_PER_COL +
              $urandom_range(0, BYTES_PER_COL - 1);
    end else begin
      op = CMD_W'($urandom_range(CMD_SET, CMD_GET));
      px = ($urandom_range(0, 3) != 0) ? hot_column + $urandom_range(0, 7)
                                       : $urandom_range(0, COLUMNS - 1);
      py = $urandom_range(0, 1) ? hot_row + $urandom_range(0, 7)
                                : $urandom_range(0, ROWS - 1);
    end
    send_word(op, px, py, idx);
  endtask

  // memory must read back as zero once the power-up clearing pass is done
  task automatic test_reset_contents;
    send_word(CMD_READ_BYTE, X_MAX, Y_MAX, 0);
    send_word(CMD_READ_BYTE, 0, 0, FRAME_BYTES - 1);
    send_word(CMD_GET, COLUMNS - 1, ROWS - 1, 0);
    send_word(CMD_READ_BYTE, 0, 0, $urandom_range(0, FRAME_BYTES - 1));
  endtask

  // corners, every command, off-panel coordinates, spare codes and clear all
  task automatic test_directed_commands;
    send_word(CMD_SET, 0, 0, 0);
    send_word(CMD_SET, COLUMNS - 1, ROWS - 1, 0);
    send_word(CMD_SET, 0, ROWS - 1, 0);
    send_word(CMD_SET, COLUMNS - 1, 0, 0);
    send_word(CMD_GET, COLUMNS - 1, ROWS - 1, 0);
    send_word(CMD_READ_BYTE, 0, 0, FRAME_BYTES - 1);
    send_word(CMD_READ_BYTE, X_MAX, Y_MAX, 0);
    send_word(CMD_TOGGLE, COLUMNS - 1, ROWS - 1, 0);
    send_word(CMD_GET, COLUMNS - 1, ROWS - 1, 0);
    send_word(CMD_TOGGLE, COLUMNS - 1, ROWS - 1, 0);
    send_word(CMD_READ_BYTE, 0, 0, FRAME_BYTES - 1);
    send_word(CMD_CLEAR, 0, 0, 0);
    send_word(CMD_GET, 0, 0, 0);
    send_word(CMD_READ_BYTE, 0, 0, BYTES_PER_COL - 1);
    send_word(CMD_SET, COLUMNS, 0, 0);
    send_word(CMD_SET, 0, ROWS, 0);
    send_word(CMD_TOGGLE, X_MAX, Y_MAX, 2**IDX_W - 1);
    send_word(CMD_CLEAR, 200, 5, 0);
    send_word(CMD_GET, COLUMNS, ROWS - 1, 0);
    send_word(CMD_GET, COLUMNS - 1, ROWS, 0);
    send_word(CMD_SPARE_6, X_MAX, Y_MAX, 2**IDX_W - 1);
    send_word(CMD_SPARE_7, 0, 0, 0);
    send_word(CMD_CLEAR_ALL, X_MAX, Y_MAX, 2**IDX_W - 1);
    send_word(CMD_READ_BYTE, 0, 0, FRAME_BYTES - 1);
    send_word(CMD_GET, 0, ROWS - 1, 0);
  endtask

  // sink holds off while words keep coming, so the input side has to stall
  task automatic test_result_holdoff;
    int unsigned k;
    wait_drained();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    hot_column    = $urandom_range(0, COLUMNS - 8);
    hot_row       = $urandom_range(0, ROWS - 8);
    sink_hold_len = HOLD_CYCLES;
    for (k = 0; k < 16; k++) send_random_word();
  endtask

  task automatic test_random_traffic;
    int unsigned seg;
    int unsigned k;
    for (seg = 0; seg < 10; seg++) begin
      hot_column    = $urandom_range(0, COLUMNS - 8);
      hot_row       = $urandom_range(0, ROWS - 8);
      // every third segment runs back to back on both sides
      src_idle_pct  = (seg % 3 == 2) ? 0 : $urandom_range(10, 50);
      sink_idle_pct = (seg % 3 == 2) ? 0 : $urandom_range(10, 50);
      for (k = 0; k < 50; k++) send_random_word();
    end
  endtask

  // closing stretch without idling: a refresh-style byte sweep mixed with edits
  task automatic test_refresh_sweep;
    int unsigned k;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    for (k = 0; k < 16; k++) begin
      send_random_word();
      send_word(CMD_READ_BYTE, $urandom_range(0, X_MAX), $urandom_range(0, Y_MAX),
                hot_column * BYTES_PER_COL + k);
    end
  endtask

  initial begin
    foreach (frame_shadow[i]) frame_shadow[i] = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_contents();
    test_directed_commands();
    test_result_holdoff();
    test_random_traffic();
    test_refresh_sweep();
    wait_drained();
    repeat (40) @(negedge clk_i);
    $display("sent %0d words (%0d clear-all, %0d off-panel pixel commands), %0d results checked",
             words_sent, clear_all_count, off_panel_count, results_checked);
    $display("set/clear/toggle/get, byte reads, spare codes, a %0d-cycle sink hold-off",
             HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
